// ===== rtl/svm_pkg.sv =====
// ---------------------------------------------------------------------------
// Sine voice mixer package
// Shared sizes, controller/datapath bundles and the quarter-wave sine table.
// ---------------------------------------------------------------------------
`default_nettype none

package svm_pkg;

  localparam int MAX_VOICES      = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int VIDX_W          = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int QTR_BITS        = SINE_TABLE_BITS - 2;
  localparam int QTR_LEN         = 1 << QTR_BITS;

  localparam int PHASE_W  = 24;
  localparam int AGE_W    = 18;
  localparam int GAIN_W   = 24;
  localparam int MIX_W    = 20;
  localparam int COUNT_W  = 5;
  localparam int SAMPLE_W = 16;
  localparam int ENV_W    = 15;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [63:0] div_tab_t [7];
  localparam div_tab_t DIV_TAB = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

  typedef logic [ENV_W-1:0] qtab_t [QTR_LEN];

  typedef struct packed {
    logic              clr;
    logic              note;
    logic              look;
    logic              up;
    logic              dn;
    logic              mix;
    logic              emit;
    logic [VIDX_W-1:0] vidx;
  } svm_cmd_t;

  typedef struct packed {
    logic vact;
    logic out_busy;
  } svm_stat_t;

  // Taylor series up to x^15 in Q30, truncating at each step
  function automatic logic [ENV_W-1:0] quarter_sine(input int unsigned r);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        v;
    x    = (64'(r) * HALF_PI_Q30) >> QTR_BITS;
    term = x;
    acc  = signed'(x);
    for (int k = 0; k < 7; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / DIV_TAB[k];
      if ((k % 2) == 0) begin
        acc = acc - signed'(term);
      end else begin
        acc = acc + signed'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    v = (unsigned'(acc) + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[ENV_W-1:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int i = 0; i < QTR_LEN; i++) begin
      t[i] = quarter_sine(i);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // quarter-wave peak, reached at the start of the odd quadrants
  localparam logic [ENV_W-1:0] QPEAK = quarter_sine(QTR_LEN);

  function automatic logic signed [SAMPLE_W-1:0] sine_lookup(
    input logic [SINE_TABLE_BITS-1:0] idx
  );
    logic [1:0]          quad;
    logic [QTR_BITS-1:0] r;
    logic [ENV_W-1:0]    s;
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    r    = idx[QTR_BITS-1:0];
    if (!quad[0]) begin
      s = QTAB[r];
    end else if (r == '0) begin
      s = QPEAK;
    end else begin
      s = QTAB[QTR_BITS'(QTR_LEN - 1) - r + 1'b1];
    end
    return quad[1] ? -signed'({1'b0, s}) : signed'({1'b0, s});
  endfunction

endpackage

`default_nettype wire

// ===== rtl/svm_ctrl.sv =====
// ---------------------------------------------------------------------------
// Sine voice mixer controller
// Sequences note-on claims and the per-voice tick walk over the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module svm_ctrl import svm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_note,
  output logic           in_ready,
  input  svm_stat_t      stat,
  output svm_cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOOK = 3'd1;
  localparam logic [2:0] ST_UP   = 3'd2;
  localparam logic [2:0] ST_DN   = 3'd3;
  localparam logic [2:0] ST_MIX  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]        state, state_next;
  logic [VIDX_W-1:0] vidx, vidx_next;
  logic              last;
  logic              accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign last     = (vidx == VIDX_W'(MAX_VOICES - 1));

  always_comb begin
    state_next = state;
    vidx_next  = vidx;
    cmd        = '0;
    cmd.vidx   = vidx;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.clr   = 1'b1;
          cmd.note  = in_note;
          vidx_next = '0;
          state_next = in_note ? ST_OUT : ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (stat.vact) begin
          cmd.look   = 1'b1;
          state_next = ST_UP;
        end else if (last) begin
          state_next = ST_OUT;
        end else begin
          vidx_next = vidx + 1'b1;
        end
      end
      ST_UP: begin
        cmd.up     = 1'b1;
        state_next = ST_DN;
      end
      ST_DN: begin
        cmd.dn     = 1'b1;
        state_next = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix = 1'b1;
        if (last) begin
          state_next = ST_OUT;
        end else begin
          vidx_next  = vidx + 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_OUT: begin
        // hold until the output register can take the result
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      vidx  <= '0;
    end else begin
      state <= state_next;
      vidx  <= vidx_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/svm_dpath.sv =====
// ---------------------------------------------------------------------------
// Sine voice mixer datapath
// Voice state, shared multiplier, envelope, mix accumulator and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module svm_dpath import svm_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  svm_cmd_t                 cmd,
  output svm_stat_t                stat,
  input  wire logic [PHASE_W-1:0]  in_step,
  input  wire logic [AGE_W-1:0]    life,
  input  wire logic [GAIN_W-1:0]   gain,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [MIX_W-1:0]         out_mix,
  output logic                     out_dropped,
  output logic [COUNT_W-1:0]       out_count
);

  logic [MAX_VOICES-1:0] active;
  logic [PHASE_W-1:0]    phase [MAX_VOICES];
  logic [PHASE_W-1:0]    step  [MAX_VOICES];
  logic [AGE_W-1:0]      age   [MAX_VOICES];

  logic signed [SAMPLE_W-1:0] sine_r;
  logic [AGE_W-1:0]           age_r;
  logic signed [AGE_W:0]      diff_r;
  logic [41:0]                up_r;
  logic [ENV_W-1:0]           env_r;
  logic [MIX_W-1:0]           mix_r;
  logic                       drop_r;

  logic [VIDX_W-1:0]   free_idx;
  logic                free_found;
  logic signed [19:0]  mul_a;
  logic signed [24:0]  mul_b;
  logic signed [44:0]  prod;
  logic [41:0]         env_min;
  logic [32:0]         env_sh;
  logic [AGE_W:0]      new_age;

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int v = MAX_VOICES - 1; v >= 0; v--) begin
      if (!active[v]) begin
        free_idx   = VIDX_W'(v);
        free_found = 1'b1;
      end
    end
  end

  // one shared multiplier, operands picked by the current step
  always_comb begin
    mul_a = signed'({2'b00, age_r});
    mul_b = signed'({1'b0, gain});
    if (cmd.dn) begin
      mul_a = 20'(diff_r);
    end else if (cmd.mix) begin
      mul_a = 20'(sine_r);
      mul_b = signed'({10'd0, env_r});
    end
  end

  assign prod    = mul_a * mul_b;
  assign env_min = (up_r < prod[41:0]) ? up_r : prod[41:0];
  assign env_sh  = env_min[41:9];
  assign new_age = {1'b0, age[cmd.vidx]} + 1'b1;

  assign stat.vact     = active[cmd.vidx];
  assign stat.out_busy = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mix_r  <= '0;
      drop_r <= cmd.note & ~free_found;
    end
    if (cmd.note && free_found) begin
      phase[free_idx] <= '0;
      age[free_idx]   <= '0;
      step[free_idx]  <= in_step;
    end
    if (cmd.look) begin
      sine_r <= sine_lookup(phase[cmd.vidx][PHASE_W-1 -: SINE_TABLE_BITS]);
      age_r  <= age[cmd.vidx];
      diff_r <= signed'({1'b0, life}) - signed'({1'b0, age[cmd.vidx]});
    end
    if (cmd.up) begin
      up_r <= prod[41:0];
    end
    if (cmd.dn) begin
      if (prod[44]) begin
        env_r <= '0;
      end else if (env_sh > 33'd32767) begin
        env_r <= 15'h7FFF;
      end else begin
        env_r <= env_sh[ENV_W-1:0];
      end
    end
    if (cmd.mix) begin
      mix_r <= mix_r + prod[15 +: MIX_W];
      phase[cmd.vidx] <= phase[cmd.vidx] + step[cmd.vidx];
      age[cmd.vidx]   <= new_age[AGE_W-1:0];
    end
    if (cmd.emit) begin
      out_mix     <= mix_r;
      out_dropped <= drop_r;
      out_count   <= COUNT_W'($countones(active));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.note && free_found) begin
        active[free_idx] <= 1'b1;
      end
      // drop the voice once it outlives the lifetime
      if (cmd.mix && (new_age > {1'b0, life})) begin
        active[cmd.vidx] <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/polyphonic_sine_voice_mixer.sv =====
// ---------------------------------------------------------------------------
// Polyphonic sine voice mixer
// Pool of sine voices with trapezoid envelopes, summed once per sample tick.
// ---------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  s_*       in         s_tvalid / s_tready     tdata phase_step, tuser req_type
//  m_*       out        m_tvalid / m_tready     tdata mix_sample, active_voices;
//                                               tuser note_dropped
//  apb       in         psel & penable          life_samples @0, ramp_gain @4
//
//  A note on is accepted when idle, then emitted once the output is free.
//  A tick walks all 16 voices: look only for an idle voice; look (table read),
//  up and down (two envelope products) and mix (sine product) for a sounding
//  voice, the three products sharing one multiplier; then the sum is emitted.
//  Reset clears the voice pool and loads the default registers.
//  A finished item waits in the output register while the next is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module polyphonic_sine_voice_mixer import svm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // phase_step[23:0]
  input  wire logic        s_tuser,   // req_type[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // mix_sample[19:0], active_voices[24:20], zero
  output logic             m_tuser,   // note_dropped[0]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic REG_LIFE = 1'b0;
  localparam logic REG_GAIN = 1'b1;

  logic [AGE_W-1:0]   life;
  logic [GAIN_W-1:0]  gain;
  svm_cmd_t           cmd;
  svm_stat_t          stat;
  logic [MIX_W-1:0]   out_mix;
  logic [COUNT_W-1:0] out_count;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      life <= AGE_W'(11025);
      gain <= GAIN_W'(7609);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_LIFE: life <= pwdata[AGE_W-1:0];
        REG_GAIN: gain <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LIFE: prdata = {14'd0, life};
      REG_GAIN: prdata = {8'd0, gain};
      default:  prdata = '0;
    endcase
  end

  svm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_note  (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  svm_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_step     (s_tdata),
    .life        (life),
    .gain        (gain),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_mix     (out_mix),
    .out_dropped (m_tuser),
    .out_count   (out_count)
  );

  assign m_tdata = {7'd0, out_count, out_mix};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again right after an accept");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_count <= COUNT_W'(MAX_VOICES)))
    else $error("active voice count beyond pool size");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (out_count == COUNT_W'(MAX_VOICES) && out_mix == '0))
    else $error("dropped note with a free voice or nonzero mix");

endmodule

`default_nettype wire
